// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and helper functions of the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   localparam int NUM_PAGES      = 8192;
   localparam int RESERVED_PAGES = 1024;

   localparam int PAGE_W     = 13;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int NUM_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W      = $clog2(NUM_WORDS);
   localparam int PAGE_IDX_W = ROW_W + BIT_W;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic STATUS_DONE      = 1'b0;
   localparam logic STATUS_EXHAUSTED = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESP
   } bpa_state_type;

   typedef struct packed {
      logic req_ready;
      logic init_wr;
      logic scan_clr;
      logic scan_en;
      logic alloc_wr;
      logic free_rd;
      logic free_wr;
      logic exhaust;
      logic rsp_load;
   } bpa_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_mode;
      logic req_page_ok;
      logic init_last;
      logic scan_hit;
      logic scan_miss_end;
      logic rsp_free;
   } bpa_sts_type;

   // busy pattern of one map row straight after reset; bits past the map stay busy
   function automatic logic [WORD_BITS-1:0] row_reset_value(input logic [ROW_W-1:0] row);
      logic [WORD_BITS-1:0] val;
      logic [31:0]          idx;
      val = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         idx    = 32'(row) * 32'(WORD_BITS) + 32'(b);
         val[b] = (idx < 32'(RESERVED_PAGES)) || (idx >= 32'(NUM_PAGES));
      end
      return val;
   endfunction

   // position of the lowest clear bit
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if
// Request and response channels of the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [bpa_pkg::PAGE_W-1:0] page;

   modport source (output valid, output mode, output page, input ready);
   modport sink   (input valid, input mode, input page, output ready);
endinterface

interface bpa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bpa_pkg::PAGE_W-1:0] page_res;
   logic                      status;

   modport source (output valid, output page_res, output status, input ready);
   modport sink   (input valid, input page_res, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: map clearing pass, first-fit scan, free read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  bpa_pkg::bpa_sts_type sts,
   output bpa_pkg::bpa_cmd_type cmd
);
   import bpa_pkg::*;

   bpa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (sts.req_valid) begin
               if (sts.req_mode == MODE_ALLOC) begin
                  state_in = ST_SCAN;
               end else if (sts.req_page_ok) begin
                  state_in = ST_FREE_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (sts.scan_hit) begin
               state_in = ST_ALLOC_WR;
            end else if (sts.scan_miss_end) begin
               state_in = ST_RESP;
            end
         end
         ST_ALLOC_WR: state_in = ST_RESP;
         ST_FREE_RD:  state_in = ST_FREE_WR;
         ST_FREE_WR:  state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_INIT: cmd.init_wr = 1'b1;
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.scan_clr  = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            cmd.exhaust = !sts.scan_hit && sts.scan_miss_end;
         end
         ST_ALLOC_WR: cmd.alloc_wr = 1'b1;
         ST_FREE_RD:  cmd.free_rd  = 1'b1;
         ST_FREE_WR:  cmd.free_wr  = 1'b1;
         ST_RESP:     cmd.rsp_load = sts.rsp_free;
         default:     cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: busy map RAM, row counter, scan pipe, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bpa_pkg::bpa_cmd_type cmd,
   output bpa_pkg::bpa_sts_type sts,
   bpa_req_if.sink              req_ch,
   bpa_rsp_if.source            rsp_ch
);
   import bpa_pkg::*;

   logic [ROW_W:0]       cnt_ff, cnt_in;
   logic                 scan_vld_ff, scan_vld_in;
   logic [ROW_W-1:0]     scan_row_ff, scan_row_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;
   logic                 res_status_ff, res_status_in;
   logic [ROW_W-1:0]     hit_row_ff, hit_row_in;
   logic [WORD_BITS-1:0] hit_data_ff, hit_data_in;
   logic [BIT_W-1:0]     hit_bit_ff, hit_bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                  wr_en;
   logic [ROW_W-1:0]      wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  rd_en;
   logic [ROW_W-1:0]      rd_addr;
   logic [WORD_BITS-1:0]  rd_data;

   logic                  req_accept;
   logic                  issue;
   logic                  scan_hit;
   logic [PAGE_IDX_W-1:0] page_idx;
   logic [ROW_W-1:0]      free_row;
   logic [BIT_W-1:0]      free_bit;
   logic [BIT_W-1:0]      zero_pos;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign issue      = cmd.scan_en && (cnt_ff != (ROW_W+1)'(NUM_WORDS));
   assign scan_hit   = scan_vld_ff && (rd_data != '1);
   assign zero_pos   = first_zero(rd_data);
   assign page_idx   = PAGE_IDX_W'(page_ff);
   assign free_row   = page_idx[PAGE_IDX_W-1:BIT_W];
   assign free_bit   = page_idx[BIT_W-1:0];

   assign req_ch.ready = cmd.req_ready;

   assign sts.req_valid     = req_ch.valid;
   assign sts.req_mode      = req_ch.mode;
   assign sts.req_page_ok   = 32'(req_ch.page) < 32'(NUM_PAGES);
   assign sts.init_last     = cnt_ff[ROW_W-1:0] == ROW_W'(NUM_WORDS - 1);
   assign sts.scan_hit      = scan_hit;
   assign sts.scan_miss_end = scan_vld_ff && (scan_row_ff == ROW_W'(NUM_WORDS - 1));
   assign sts.rsp_free      = !rsp_valid_ff || rsp_ch.ready;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[ROW_W-1:0];
      wr_data = row_reset_value(cnt_ff[ROW_W-1:0]);
      if (cmd.init_wr) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_wr) begin
         wr_en   = 1'b1;
         wr_addr = hit_row_ff;
         wr_data = hit_data_ff | (WORD_BITS'(1) << hit_bit_ff);
      end else if (cmd.free_wr) begin
         wr_en   = 1'b1;
         wr_addr = free_row;
         wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
      end
   end

   assign rd_en   = issue || cmd.free_rd;
   assign rd_addr = cmd.free_rd ? free_row : cnt_ff[ROW_W-1:0];

   always_comb begin
      cnt_in        = cnt_ff;
      scan_vld_in   = issue;
      scan_row_in   = cnt_ff[ROW_W-1:0];
      page_in       = page_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      hit_row_in    = hit_row_ff;
      hit_data_in   = hit_data_ff;
      hit_bit_in    = hit_bit_ff;
      if (cmd.init_wr || issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.scan_clr) begin
         cnt_in      = '0;
         scan_vld_in = 1'b0;
      end
      if (req_accept) begin
         page_in       = req_ch.page;
         res_page_in   = req_ch.page;
         res_status_in = STATUS_DONE;
      end
      if (cmd.scan_en && scan_hit) begin
         hit_row_in  = scan_row_ff;
         hit_data_in = rd_data;
         hit_bit_in  = zero_pos;
         res_page_in = PAGE_W'({scan_row_ff, zero_pos});
      end
      if (cmd.exhaust) begin
         res_page_in   = '0;
         res_status_in = STATUS_EXHAUSTED;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_page_in   = res_page_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_row_ff   <= scan_row_in;
      page_ff       <= page_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      hit_row_ff    <= hit_row_in;
      hit_data_ff   <= hit_data_in;
      hit_bit_ff    <= hit_bit_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.page_res = rsp_page_ff;
   assign rsp_ch.status   = rsp_status_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a one-bit-per-page busy map.
// ----------------------------------------------------------------------------
// The busy map sits in a RAM of NUM_WORDS rows of 32 bits (256 rows for 8192
// pages). After reset the block runs a clearing pass over all NUM_WORDS rows
// that writes the reset pattern, reserved pages busy, before it takes its first
// item. One item is worked on at a time. An allocate reads the map one row per
// cycle through the RAM read port from row 0 upward and takes the lowest free
// page of the first row that has one; a full map returns the exhausted status.
// A free of a page inside the map is a read-modify-write of one row. A finished
// result waits in the output register, so the next item is accepted while it
// is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch
);
   import bpa_pkg::*;

   bpa_cmd_type cmd;
   bpa_sts_type sts;

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   bpa_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while previous one still at work");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_wr, cmd.alloc_wr, cmd.free_wr}))
      else $error("conflicting map writes");

   a_no_ready_in_init: assert property (@(posedge clock) disable iff (reset)
      cmd.init_wr |-> !req_ch.ready)
      else $error("item taken during clearing pass");

   a_exhausted_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_EXHAUSTED)) |-> (rsp_ch.page_res == '0))
      else $error("exhausted result carries a page number");
`endif

endmodule

`default_nettype wire
